// File: rtl/tfmd_pkg.sv
`timescale 1ns / 1ps

package tfmd_pkg;

   // Store geometry
   localparam int DEPTH        = 64;
   localparam int FILTER_SLOTS = 6;
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int REQ_W        = 3;
   localparam int TYPE_W       = 32;
   localparam int HANDLE_W     = 16;
   localparam int STATUS_W     = 2;
   localparam int FCOUNT_W     = 3;
   localparam int CSR_IDX_W    = $clog2(FILTER_SLOTS + 2);
   localparam int CSR_DATA_W   = 32;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_PEEK_HEAD = 3'd3;
   localparam logic [REQ_W-1:0] REQ_POP_FILT  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_PEEK_FILT = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   // Register indexes
   localparam int CSR_FILTER_COUNT = 0;
   localparam int CSR_FILTER_BASE  = 1;
   localparam int CSR_QUEUE_ENABLE = FILTER_SLOTS + 1;

   // Cell operations
   localparam logic [1:0] CELL_HOLD       = 2'd0;
   localparam logic [1:0] CELL_LOAD       = 2'd1;
   localparam logic [1:0] CELL_FROM_LEFT  = 2'd2;
   localparam logic [1:0] CELL_FROM_RIGHT = 2'd3;

   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [DEPTH-1:0]     vec_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef struct packed {
      logic [TYPE_W-1:0]   msg_type;
      logic [HANDLE_W-1:0] msg_handle;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      logic       hit_en;
   } cell_ctl_type;

   typedef struct packed {
      logic [FILTER_SLOTS-1:0]             active;
      logic [FILTER_SLOTS-1:0][TYPE_W-1:0] words;
   } filter_set_type;

endpackage

// File: rtl/tfmd_cell.sv
`timescale 1ns / 1ps

module tfmd_cell (
   input  logic                     clock,
   input  tfmd_pkg::cell_ctl_type   ctl,
   input  tfmd_pkg::filter_set_type filters,
   input  logic                     occupied,
   input  tfmd_pkg::entry_type      new_entry,
   input  tfmd_pkg::entry_type      left_entry,
   input  tfmd_pkg::entry_type      right_entry,
   output tfmd_pkg::entry_type      entry,
   output logic                     hit
);

   tfmd_pkg::entry_type entry_ff;
   tfmd_pkg::entry_type entry_in;
   logic                hit_ff;
   logic                match;

   // Next slot content: hold, load, or shift from a neighbor
   always_comb begin
      case (ctl.op)
         tfmd_pkg::CELL_HOLD:       entry_in = entry_ff;
         tfmd_pkg::CELL_LOAD:       entry_in = new_entry;
         tfmd_pkg::CELL_FROM_LEFT:  entry_in = left_entry;
         tfmd_pkg::CELL_FROM_RIGHT: entry_in = right_entry;
         default:                   entry_in = entry_ff;
      endcase
   end

   // Compare held type against every active filter word
   always_comb begin
      match = 1'b0;
      for (int j = 0; j < tfmd_pkg::FILTER_SLOTS; j++) begin
         if (filters.active[j] && (filters.words[j] == entry_ff.msg_type)) begin
            match = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.hit_en) begin
         hit_ff <= occupied && match;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// File: rtl/type_filtered_message_deque_top.sv
`timescale 1ns / 1ps

// Ordered message store of 64 entries (type word plus handle) built as a row of
// cells that shift toward the tail on a head push and toward the head when an
// entry is removed, so a removal from the middle closes the gap in one shift.
// An item is accepted only while the control is idle, so the block takes no new
// item before it is through with the last one: the cycle it is taken, when every
// cell compares its type with the active filter words; a cycle that picks the
// hit nearest the head with a 64-bit find-first; and a cycle in which the row
// shifts and the result is registered. The apply cycle waits for as long as an
// earlier result is still held on the result channel. The next item is accepted
// in the cycle after the apply, even while its result still waits. Every item
// gives exactly one result. Configuration is written through the csr_ port; the
// user must write it only while the block is idle, which the block itself does
// not enforce. No clearing pass follows reset.
module type_filtered_message_deque_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [tfmd_pkg::REQ_W-1:0]              req_type,
   input  logic [tfmd_pkg::TYPE_W-1:0]             req_msg_type,
   input  logic [tfmd_pkg::HANDLE_W-1:0]           req_msg_handle,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [tfmd_pkg::STATUS_W-1:0]           rsp_status,
   output logic [tfmd_pkg::TYPE_W-1:0]             rsp_out_type,
   output logic [tfmd_pkg::HANDLE_W-1:0]           rsp_out_handle,
   output logic [tfmd_pkg::CNT_W-1:0]              rsp_fill_count,
   // configuration
   input  logic                                    csr_write_en,
   input  logic [tfmd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tfmd_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PICK  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // configuration registers
   logic [tfmd_pkg::FCOUNT_W-1:0]                         fcount_ff;
   logic [tfmd_pkg::FILTER_SLOTS-1:0][tfmd_pkg::TYPE_W-1:0] fwords_ff;
   logic                                                  enabled_ff;
   tfmd_pkg::filter_set_type                              filters;

   // request capture
   logic [tfmd_pkg::REQ_W-1:0] req_type_ff;
   tfmd_pkg::entry_type        req_entry_ff;
   tfmd_pkg::entry_type        req_entry;

   // row state
   tfmd_pkg::count_type count_ff;
   tfmd_pkg::count_type count_in;
   tfmd_pkg::vec_type   occupied;
   tfmd_pkg::vec_type   hits;
   tfmd_pkg::vec_type   first_hit;
   tfmd_pkg::vec_type   head_sel;
   tfmd_pkg::vec_type   sel_in;
   tfmd_pkg::vec_type   sel_ff;
   tfmd_pkg::vec_type   ge_ff;
   tfmd_pkg::entry_type cell_data [tfmd_pkg::DEPTH];
   tfmd_pkg::entry_type readout;

   // result register
   logic                          rsp_valid_ff;
   logic [tfmd_pkg::STATUS_W-1:0] status_ff;
   logic [tfmd_pkg::STATUS_W-1:0] status_in;
   tfmd_pkg::entry_type           out_ff;
   tfmd_pkg::entry_type           out_in;

   logic accept;
   logic advance;
   logic is_push;
   logic is_push_tail;
   logic is_push_head;
   logic is_take;
   logic is_pop;
   logic is_filtered;
   logic full;
   logic found;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_entry = '{msg_type: req_msg_type, msg_handle: req_msg_handle};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff  <= '0;
         fwords_ff  <= '0;
         enabled_ff <= 1'b1;
      end else if (csr_write_en) begin
         if (csr_index == tfmd_pkg::csr_idx_type'(tfmd_pkg::CSR_FILTER_COUNT)) begin
            fcount_ff <= csr_wdata[tfmd_pkg::FCOUNT_W-1:0];
         end
         for (int j = 0; j < tfmd_pkg::FILTER_SLOTS; j++) begin
            if (csr_index == tfmd_pkg::csr_idx_type'(tfmd_pkg::CSR_FILTER_BASE + j)) begin
               fwords_ff[j] <= csr_wdata[tfmd_pkg::TYPE_W-1:0];
            end
         end
         if (csr_index == tfmd_pkg::csr_idx_type'(tfmd_pkg::CSR_QUEUE_ENABLE)) begin
            enabled_ff <= csr_wdata[0];
         end
      end
   end

   // counts above the slot number saturate naturally through this compare
   always_comb begin
      for (int j = 0; j < tfmd_pkg::FILTER_SLOTS; j++) begin
         filters.active[j] = (int'(fcount_ff) > j);
      end
      filters.words = fwords_ff;
   end

   // capture request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff  <= req_type;
         req_entry_ff <= req_entry;
      end
   end

   // request decode
   assign is_push_tail = (req_type_ff == tfmd_pkg::REQ_PUSH_TAIL);
   assign is_push_head = (req_type_ff == tfmd_pkg::REQ_PUSH_HEAD);
   assign is_push      = is_push_tail || is_push_head;
   assign is_pop       = (req_type_ff == tfmd_pkg::REQ_POP_HEAD)
                      || (req_type_ff == tfmd_pkg::REQ_POP_FILT);
   assign is_take      = is_pop
                      || (req_type_ff == tfmd_pkg::REQ_PEEK_HEAD)
                      || (req_type_ff == tfmd_pkg::REQ_PEEK_FILT);
   assign is_filtered  = (req_type_ff == tfmd_pkg::REQ_POP_FILT)
                      || (req_type_ff == tfmd_pkg::REQ_PEEK_FILT);
   assign full         = (count_ff == tfmd_pkg::count_type'(tfmd_pkg::DEPTH));
   assign found        = |sel_ff;
   assign advance      = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);

   // target pick: hit nearest the head, or the head when unfiltered or no filter is set
   assign first_hit = hits & (~hits + tfmd_pkg::vec_type'(1));
   assign head_sel  = {{(tfmd_pkg::DEPTH-1){1'b0}}, (count_ff != '0)};
   assign sel_in    = (is_filtered && (fcount_ff != '0)) ? first_hit : head_sel;

   always_ff @(posedge clock) begin
      if (state_ff == S_PICK) begin
         sel_ff <= sel_in;
         ge_ff  <= ~(sel_in - tfmd_pkg::vec_type'(1));
      end
   end

   // row of cells
   for (genvar i = 0; i < tfmd_pkg::DEPTH; i++) begin : g_cell
      tfmd_pkg::entry_type    left_entry;
      tfmd_pkg::entry_type    right_entry;
      tfmd_pkg::cell_ctl_type ctl;

      assign occupied[i] = (count_ff > tfmd_pkg::count_type'(i));

      if (i == 0) begin : g_first
         assign left_entry = req_entry_ff;
      end else begin : g_left
         assign left_entry = cell_data[i-1];
      end

      if (i == tfmd_pkg::DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = cell_data[i+1];
      end

      // per-cell operation
      always_comb begin
         ctl.hit_en = accept;
         ctl.op     = tfmd_pkg::CELL_HOLD;
         if (advance) begin
            if (is_push_tail && !full) begin
               if (count_ff == tfmd_pkg::count_type'(i)) begin
                  ctl.op = tfmd_pkg::CELL_LOAD;
               end
            end else if (is_push_head && !full) begin
               ctl.op = (i == 0) ? tfmd_pkg::CELL_LOAD : tfmd_pkg::CELL_FROM_LEFT;
            end else if (is_pop && found && ge_ff[i]) begin
               ctl.op = tfmd_pkg::CELL_FROM_RIGHT;
            end
         end
      end

      tfmd_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .filters     (filters),
         .occupied    (occupied[i]),
         .new_entry   (req_entry_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_data[i]),
         .hit         (hits[i])
      );
   end

   // read out the selected cell
   always_comb begin
      readout = '0;
      for (int i = 0; i < tfmd_pkg::DEPTH; i++) begin
         if (sel_ff[i]) begin
            readout = readout | cell_data[i];
         end
      end
   end

   // result and count
   always_comb begin
      status_in = tfmd_pkg::STATUS_OK;
      out_in    = '0;
      count_in  = count_ff;
      if (is_push) begin
         if (full) begin
            status_in = tfmd_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + tfmd_pkg::count_type'(1);
         end
      end else if (is_take) begin
         if (!found) begin
            status_in = enabled_ff ? tfmd_pkg::STATUS_EMPTY : tfmd_pkg::STATUS_DISABLED;
         end else begin
            out_in = readout;
            if (is_pop) begin
               count_in = count_ff - tfmd_pkg::count_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         out_ff    <= out_in;
      end
   end

   // control state
   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = accept ? S_PICK : S_IDLE;
         S_PICK:  state_in = S_APPLY;
         S_APPLY: state_in = advance ? S_IDLE : S_APPLY;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // count goes out with the result, as held after the item
   logic [tfmd_pkg::CNT_W-1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         fill_ff <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_type   = out_ff.msg_type;
   assign rsp_out_handle = out_ff.msg_handle;
   assign rsp_fill_count = fill_ff;

endmodule

// File: tb/type_filtered_message_deque_top_tb.sv
`timescale 1ns / 1ps

module type_filtered_message_deque_top_tb;

   typedef logic [tfmd_pkg::REQ_W-1:0]      code_type;
   typedef logic [tfmd_pkg::TYPE_W-1:0]     word_type;
   typedef logic [tfmd_pkg::HANDLE_W-1:0]   handle_type;
   typedef logic [tfmd_pkg::STATUS_W-1:0]   status_type;
   typedef logic [tfmd_pkg::FCOUNT_W-1:0]   fcount_type;
   typedef logic [tfmd_pkg::CSR_DATA_W-1:0] csr_data_type;

   // Request codes the block must treat as no-ops
   localparam code_type REQ_RSVD_6 = 3'd6;
   localparam code_type REQ_RSVD_7 = 3'd7;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 170;

   typedef struct {
      status_type          status;
      word_type            msg_type;
      handle_type          msg_handle;
      tfmd_pkg::count_type fill;
   } outcome_type;

   // Mirror of the deque plus the queue of outcomes still owed by the block
   class deque_scoreboard;
      tfmd_pkg::entry_type held[$];
      fcount_type          filt_count;
      word_type            filt_word[tfmd_pkg::FILTER_SLOTS];
      bit                  enabled;
      outcome_type         awaited_outcomes[$];
      int                  errors;
      int                  requests;
      int                  checked;
      int                  refused;
      int                  disabled_reports;
      int                  deep_picks;
      int                  peak_fill;

      function new();
         filt_count = '0;
         foreach (filt_word[j]) filt_word[j] = '0;
         enabled = 1'b1;
      endfunction

      function void set_register(int idx, csr_data_type value);
         if (idx == tfmd_pkg::CSR_FILTER_COUNT)
            filt_count = value[tfmd_pkg::FCOUNT_W-1:0];
         else if (idx >= tfmd_pkg::CSR_FILTER_BASE
                  && idx < tfmd_pkg::CSR_FILTER_BASE + tfmd_pkg::FILTER_SLOTS)
            filt_word[idx - tfmd_pkg::CSR_FILTER_BASE] = value[tfmd_pkg::TYPE_W-1:0];
         else if (idx == tfmd_pkg::CSR_QUEUE_ENABLE)
            enabled = value[0];
      endfunction

      // Position a head or filtered request acts on, -1 when nothing matches
      function int locate(bit filtered);
         int n;
         if (held.size() == 0) return -1;
         if (!filtered || filt_count == 0) return 0;
         n = (int'(filt_count) > tfmd_pkg::FILTER_SLOTS) ? tfmd_pkg::FILTER_SLOTS
                                                         : int'(filt_count);
         foreach (held[i])
            for (int j = 0; j < n; j++)
               if (filt_word[j] == held[i].msg_type) return i;
         return -1;
      endfunction

      // Predict the outcome of one accepted request and update the mirror
      function void apply_request(code_type code, word_type mtype, handle_type mhandle);
         outcome_type         o;
         tfmd_pkg::entry_type e;
         int                  pos;
         o.status     = tfmd_pkg::STATUS_OK;
         o.msg_type   = '0;
         o.msg_handle = '0;
         e.msg_type   = mtype;
         e.msg_handle = mhandle;
         requests++;
         case (code)
            tfmd_pkg::REQ_PUSH_TAIL, tfmd_pkg::REQ_PUSH_HEAD: begin
               if (held.size() >= tfmd_pkg::DEPTH) begin
                  o.status = tfmd_pkg::STATUS_FULL;
                  refused++;
               end else if (code == tfmd_pkg::REQ_PUSH_TAIL)
                  held.push_back(e);
               else
                  held.push_front(e);
            end
            tfmd_pkg::REQ_POP_HEAD, tfmd_pkg::REQ_PEEK_HEAD,
            tfmd_pkg::REQ_POP_FILT, tfmd_pkg::REQ_PEEK_FILT: begin
               pos = locate(code == tfmd_pkg::REQ_POP_FILT
                            || code == tfmd_pkg::REQ_PEEK_FILT);
               if (pos < 0) begin
                  o.status = enabled ? tfmd_pkg::STATUS_EMPTY : tfmd_pkg::STATUS_DISABLED;
                  if (!enabled) disabled_reports++;
               end else begin
                  o.msg_type   = held[pos].msg_type;
                  o.msg_handle = held[pos].msg_handle;
                  if (pos > 0) deep_picks++;
                  if (code == tfmd_pkg::REQ_POP_HEAD || code == tfmd_pkg::REQ_POP_FILT)
                     held.delete(pos);
               end
            end
            default: ;
         endcase
         o.fill = tfmd_pkg::count_type'(held.size());
         if (held.size() > peak_fill) peak_fill = held.size();
         awaited_outcomes.push_back(o);
      endfunction

      function void check_result(status_type status, word_type otype,
                                 handle_type ohandle, tfmd_pkg::count_type fill);
         outcome_type o;
         if (awaited_outcomes.size() == 0) begin
            $error("result with no request outstanding: status %0d type %h handle %h",
                   status, otype, ohandle);
            errors++;
            return;
         end
         o = awaited_outcomes.pop_front();
         checked++;
         if (status !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, status);
            errors++;
         end
         if (otype !== o.msg_type) begin
            $error("out_type: expected %h, got %h", o.msg_type, otype);
            errors++;
         end
         if (ohandle !== o.msg_handle) begin
            $error("out_handle: expected %h, got %h", o.msg_handle, ohandle);
            errors++;
         end
         if (fill !== o.fill) begin
            $error("fill_count: expected %0d, got %0d", o.fill, fill);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_outcomes.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   code_type              req_type;
   word_type              req_msg_type;
   handle_type            req_msg_handle;
   logic                  rsp_valid;
   logic                  rsp_ready;
   status_type            rsp_status;
   word_type              rsp_out_type;
   handle_type            rsp_out_handle;
   tfmd_pkg::count_type   rsp_fill_count;
   logic                  csr_write_en;
   tfmd_pkg::csr_idx_type csr_index;
   csr_data_type          csr_wdata;

   deque_scoreboard       sb;
   bit                    quiet;
   int                    stall_left;
   word_type              type_pool[8];
   word_type              filter_plan[tfmd_pkg::FILTER_SLOTS];
   int                    push_pct[PHASES] = '{50, 85, 60, 25, 85, 15, 50, 50};

   type_filtered_message_deque_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_msg_type   (req_msg_type),
      .req_msg_handle (req_msg_handle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_type   (rsp_out_type),
      .rsp_out_handle (rsp_out_handle),
      .rsp_fill_count (rsp_fill_count),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: check every accepted item, stall in random bursts unless quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_out_type, rsp_out_handle, rsp_fill_count);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(1, 14)) - 1;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   function automatic handle_type any_handle();
      return handle_type'($urandom);
   endfunction

   // Hold one request on the channel until it is taken
   task automatic send_item(input code_type code, input word_type mtype,
                            input handle_type mhandle);
      req_valid      <= 1'b1;
      req_type       <= code;
      req_msg_type   <= mtype;
      req_msg_handle <= mhandle;
      do @(posedge clock); while (!req_ready);
      sb.apply_request(code, mtype, mhandle);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_random(input int pct);
      code_type code;
      word_type mtype;
      int       roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 3)
         code = roll[0] ? REQ_RSVD_7 : REQ_RSVD_6;
      else if (roll < pct)
         code = $urandom_range(0, 1) ? tfmd_pkg::REQ_PUSH_HEAD : tfmd_pkg::REQ_PUSH_TAIL;
      else begin
         case ($urandom_range(0, 3))
            0: code = tfmd_pkg::REQ_POP_HEAD;
            1: code = tfmd_pkg::REQ_PEEK_HEAD;
            2: code = tfmd_pkg::REQ_POP_FILT;
            default: code = tfmd_pkg::REQ_PEEK_FILT;
         endcase
      end
      // mostly pooled types so the filters find something
      mtype = ($urandom_range(0, 9) < 7) ? type_pool[$urandom_range(0, 7)] : $urandom;
      if (!quiet && $urandom_range(0, 7) == 0) pause_sender(int'($urandom_range(1, 14)));
      send_item(code, mtype, handle_type'($urandom_range(0, 65535)));
   endtask

   // Wait until every outstanding result is back, plus the pipeline depth
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input int idx, input csr_data_type value);
      csr_write_en <= 1'b1;
      csr_index    <= tfmd_pkg::csr_idx_type'(idx);
      csr_wdata    <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   // Load count, the filter words from filter_plan and the enable bit
   task automatic program_csrs(input fcount_type fcount, input bit enable_q);
      write_csr(tfmd_pkg::CSR_FILTER_COUNT, csr_data_type'({$urandom, fcount}));
      for (int j = 0; j < tfmd_pkg::FILTER_SLOTS; j++)
         write_csr(tfmd_pkg::CSR_FILTER_BASE + j, filter_plan[j]);
      write_csr(tfmd_pkg::CSR_QUEUE_ENABLE, csr_data_type'({$urandom, enable_q}));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      fcount_type fcount;
      bit         enable_q;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = '0;
      req_msg_type   = '0;
      req_msg_handle = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      quiet          = 1'b0;
      sb             = new();
      type_pool[0]   = '0;
      type_pool[1]   = '1;
      for (int i = 2; i < 8; i++) type_pool[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty store, unfiltered forms, no-op codes
      send_item(tfmd_pkg::REQ_POP_HEAD, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_PEEK_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_PEEK_HEAD, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_PUSH_TAIL, '1, '1);
      send_item(tfmd_pkg::REQ_PUSH_HEAD, '0, '0);
      send_item(tfmd_pkg::REQ_PUSH_TAIL, type_pool[2], 16'hA5A5);
      send_item(tfmd_pkg::REQ_PEEK_HEAD, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_PEEK_FILT, $urandom, any_handle());
      send_item(REQ_RSVD_6, $urandom, any_handle());
      send_item(REQ_RSVD_7, $urandom, any_handle());

      // Removal from the middle and the tail, then misses while disabled
      drain();
      filter_plan = '{'1, type_pool[2], '0, '0, '0, '0};
      program_csrs(3'd2, 1'b0);
      send_item(tfmd_pkg::REQ_PEEK_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_PEEK_HEAD, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_HEAD, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_HEAD, $urandom, any_handle());

      // Oversized filter count: only the last word matches
      drain();
      filter_plan = '{type_pool[5], type_pool[5], type_pool[5], type_pool[5],
                      type_pool[5], type_pool[4]};
      program_csrs(3'd7, 1'b1);
      send_item(tfmd_pkg::REQ_PUSH_TAIL, type_pool[3], 16'h0001);
      send_item(tfmd_pkg::REQ_PUSH_TAIL, type_pool[4], 16'hFFFE);
      send_item(tfmd_pkg::REQ_PEEK_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_FILT, $urandom, any_handle());
      send_item(tfmd_pkg::REQ_POP_FILT, $urandom, any_handle());

      // Random phases: filling, draining and mixed traffic under varied filters
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: fcount = 3'd0;
            1: fcount = fcount_type'(tfmd_pkg::FILTER_SLOTS);
            2: fcount = 3'd1;
            3: fcount = 3'd7;
            default: fcount = fcount_type'($urandom_range(0, 7));
         endcase
         enable_q = (p == 2 || p == 5) ? 1'b0
                  : ((p < 2) ? 1'b1 : 1'($urandom_range(0, 1)));
         foreach (filter_plan[j])
            filter_plan[j] = ($urandom_range(0, 4) != 0) ? type_pool[$urandom_range(0, 7)]
                                                          : $urandom;
         program_csrs(fcount, enable_q);
         quiet = (p == PHASES - 1);
         repeat (PHASE_ITEMS) send_random(push_pct[p]);
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests, %0d results checked; peak fill %0d, %0d refused pushes,",
               sb.requests, sb.checked, sb.peak_fill, sb.refused);
      $display("%0d misses while disabled, %0d filtered picks behind the head",
               sb.disabled_reports, sb.deep_picks);
      if (sb.errors == 0)
         $display("type_filtered_message_deque_top_tb OK");
      else
         $display("type_filtered_message_deque_top_tb NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("type_filtered_message_deque_top_tb NOT OK");
      $finish;
   end

endmodule

// File: files.f
rtl/tfmd_pkg.sv
rtl/tfmd_cell.sv
rtl/type_filtered_message_deque_top.sv
tb/type_filtered_message_deque_top_tb.sv
